[rtl/core/msl_pkg.sv]
// Shared types, command codes and register indexes for the servo slew limiter.
// No dependencies; used by every module in rtl/core.
package msl_pkg;

  localparam int unsigned FULL_SCALE_DEG = 180;
  localparam int unsigned PULSE_MAX      = 4095;

  // reciprocal of 180 for a 20 bit dividend: q = (x * RECIP_180) >> RECIP_SHIFT
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [20:0] RECIP_180   = 21'((64'd1 << RECIP_SHIFT) / 180 + 1);

  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_NEUTRAL = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_MAX_SAFE  = 3'd0;
  localparam logic [2:0] REG_STEP      = 3'd1;
  localparam logic [2:0] REG_PERIOD    = 3'd2;
  localparam logic [2:0] REG_MIN_PULSE = 3'd3;
  localparam logic [2:0] REG_MAX_PULSE = 3'd4;

  // control shared by every cell of the chain
  typedef struct packed {
    logic       update;
    logic       shift;
    logic [7:0] step;
  } cell_ctrl_t;

  // one channel on its way through the pulse mapping stages
  typedef struct packed {
    logic [2:0] channel;
    logic [7:0] angle;
    logic       last;
  } result_t;

  // clamp a requested angle to the safe maximum and to full scale
  function automatic logic [7:0] clamp_angle(input logic [7:0] a, input logic [7:0] max_safe);
    logic [7:0] r;
    r = a;
    if (r > max_safe) r = max_safe;
    if (r > 8'(FULL_SCALE_DEG)) r = 8'(FULL_SCALE_DEG);
    return r;
  endfunction

endpackage

[rtl/core/msl_cell.sv]
// One channel cell: goal angle, present angle and a result slot in the drain chain.
// Depends on msl_pkg.
module msl_cell #(
  parameter logic [7:0] RESET_DEG = 8'd0
) (
  input  logic                clk,
  input  logic                rst,
  input  msl_pkg::cell_ctrl_t ctrl,
  input  logic                goal_we,
  input  logic [7:0]          goal_val,
  input  logic [7:0]          slot_in,
  output logic [7:0]          slot_out
);

  logic [7:0] goal;
  logic [7:0] present;
  logic [7:0] slot;
  logic [7:0] slewed;
  logic [7:0] diff;

  // move present toward goal by at most one step
  always_comb begin
    slewed = present;
    diff   = 8'd0;
    if (present < goal) begin
      diff   = goal - present;
      slewed = (diff > ctrl.step) ? present + ctrl.step : goal;
    end else if (present > goal) begin
      diff   = present - goal;
      slewed = (diff > ctrl.step) ? present - ctrl.step : goal;
    end
  end

  // angle state
  always_ff @(posedge clk) begin
    if (rst) begin
      goal    <= RESET_DEG;
      present <= RESET_DEG;
    end else begin
      if (goal_we) goal <= goal_val;
      if (ctrl.update) present <= slewed;
    end
  end

  // result slot: loaded on update, then handed toward cell 0
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      slot <= slewed;
    end else if (ctrl.shift) begin
      slot <= slot_in;
    end
  end

  assign slot_out = slot;

endmodule

[rtl/core/msl_pulse_map.sv]
// Pulse width mapping pipeline: multiply by span, divide by 180, add minimum.
// Holds the output register of the result stream. Depends on msl_pkg.
module msl_pulse_map (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  msl_pkg::result_t in_res,
  input  logic [11:0]      min_pulse,
  input  logic [11:0]      max_pulse,
  output logic             advance,
  output logic             out_valid,
  output msl_pkg::result_t out_res,
  output logic [11:0]      out_pulse,
  input  logic             out_ready
);

  logic               v1;
  msl_pkg::result_t   r1;
  logic signed [21:0] prod;
  logic               v2;
  msl_pkg::result_t   r2;
  logic               neg2;
  logic [11:0]        quot;

  logic signed [12:0] span;
  logic signed [21:0] prod_next;
  logic [19:0]        mag;
  logic [40:0]        recip_prod;
  logic signed [13:0] sum;
  logic [11:0]        pulse_next;

  assign advance = !out_valid || out_ready;

  // stage 1: signed span times angle
  assign span      = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
  assign prod_next = 22'(span * $signed({1'b0, in_res.angle}));

  // stage 2: magnitude divided by 180 through the reciprocal
  assign mag        = prod[21] ? 20'(-prod) : 20'(prod);
  assign recip_prod = 41'(mag) * 41'(msl_pkg::RECIP_180);

  // stage 3: add minimum with quotient truncated toward zero, keep in range
  always_comb begin
    sum = $signed({2'b00, min_pulse}) + (neg2 ? -$signed({2'b00, quot})
                                               : $signed({2'b00, quot}));
    if (sum < 14'sd0) begin
      pulse_next = 12'd0;
    end else if (sum > 14'(msl_pkg::PULSE_MAX)) begin
      pulse_next = 12'(msl_pkg::PULSE_MAX);
    end else begin
      pulse_next = sum[11:0];
    end
  end

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (advance) begin
      r1        <= in_res;
      prod      <= prod_next;
      r2        <= r1;
      neg2      <= prod[21];
      quot      <= recip_prod[msl_pkg::RECIP_SHIFT +: 12];
      out_res   <= r2;
      out_pulse <= pulse_next;
    end
  end

endmodule

[rtl/core/multi_channel_servo_slew_limiter_core.sv]
// Multi-channel servo slew limiter: top level with command decode, tick counter,
// cell chain and drain sequencer. Depends on msl_pkg, msl_cell, msl_pulse_map.

// Set-target and all-neutral commands and ticks that do not close an update
// period are accepted without holding off the input. A tick that closes the period
// slews every channel at once in its cell and then drains the cell chain toward
// cell 0, one channel per cycle when the result stream does not stall; the input
// is held off until the drain ends. The first result passes from the cell slots
// through the multiply, divide-by-180 and add stages of the pulse mapping pipeline.
module multi_channel_servo_slew_limiter_core #(
  parameter int CHANNELS    = 6,
  parameter int NEUTRAL_DEG = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cmd, [4:2] channel, [12:5] target_angle
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] out_channel, [10:3] current_angle, [22:11] pulse_us
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0]  safe_max_deg;
  logic [7:0]  step_degrees;
  logic [9:0]  update_period_ms;
  logic [11:0] min_pulse_us;
  logic [11:0] max_pulse_us;

  logic [9:0]       elapsed_ms;
  logic [9:0]       elapsed_next;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  logic             accept;
  msl_pkg::cmd_t    cmd;
  logic [2:0]       in_channel;
  logic [7:0]       in_angle;
  logic             update;
  logic             neutral;
  logic             set_goal;
  logic [7:0]       goal_val;

  msl_pkg::cell_ctrl_t ctrl;
  logic [CHANNELS-1:0] goal_we;
  logic [7:0]          slot [CHANNELS+1];

  logic             advance;
  logic             feed;
  msl_pkg::result_t feed_res;
  msl_pkg::result_t out_res;
  logic [11:0]      out_pulse;

  // input decode
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign cmd        = msl_pkg::cmd_t'(s_axis_tdata[1:0]);
  assign in_channel = s_axis_tdata[4:2];
  assign in_angle   = s_axis_tdata[12:5];
  assign s_axis_tready = !busy;

  assign set_goal = accept && (cmd == msl_pkg::CMD_SET);
  assign neutral  = accept && (cmd == msl_pkg::CMD_NEUTRAL);
  assign goal_val = set_goal ? msl_pkg::clamp_angle(in_angle, safe_max_deg)
                             : msl_pkg::clamp_angle(8'(NEUTRAL_DEG), safe_max_deg);

  // tick counter, saturating, update when the period is reached
  always_comb begin
    elapsed_next = (elapsed_ms != 10'h3FF) ? elapsed_ms + 10'd1 : elapsed_ms;
  end
  assign update = accept && (cmd == msl_pkg::CMD_TICK) && (elapsed_next >= update_period_ms);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      safe_max_deg     <= 8'd180;
      step_degrees     <= 8'd1;
      update_period_ms <= 10'd20;
      min_pulse_us     <= 12'd500;
      max_pulse_us     <= 12'd2500;
    end else if (cfg_we) begin
      case (cfg_index)
        msl_pkg::REG_MAX_SAFE:  safe_max_deg     <= cfg_data[7:0];
        msl_pkg::REG_STEP:      step_degrees     <= cfg_data[7:0];
        msl_pkg::REG_PERIOD:    update_period_ms <= cfg_data[9:0];
        msl_pkg::REG_MIN_PULSE: min_pulse_us     <= cfg_data;
        msl_pkg::REG_MAX_PULSE: max_pulse_us     <= cfg_data;
        default: ;
      endcase
    end
  end

  // elapsed time
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms <= 10'd0;
    end else if (accept && (cmd == msl_pkg::CMD_TICK)) begin
      elapsed_ms <= update ? 10'd0 : elapsed_next;
    end
  end

  // drain sequencer: one channel per cycle from cell 0 into the pulse pipeline while it advances
  assign feed = busy && advance;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (update) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (feed) begin
      if (cnt == CNT_W'(CHANNELS - 1)) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

  assign ctrl.update = update;
  assign ctrl.shift  = feed;
  assign ctrl.step   = step_degrees;

  // cell chain
  assign slot[CHANNELS] = 8'd0;
  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    assign goal_we[i] = neutral || (set_goal && (32'(in_channel) == i));
    msl_cell #(
      .RESET_DEG (8'(NEUTRAL_DEG))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .goal_we  (goal_we[i]),
      .goal_val (goal_val),
      .slot_in  (slot[i+1]),
      .slot_out (slot[i])
    );
  end

  assign feed_res.channel = 3'(cnt);
  assign feed_res.angle   = slot[0];
  assign feed_res.last    = (cnt == CNT_W'(CHANNELS - 1));

  // pulse mapping and output register
  msl_pulse_map u_pulse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (busy),
    .in_res    (feed_res),
    .min_pulse (min_pulse_us),
    .max_pulse (max_pulse_us),
    .advance   (advance),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res),
    .out_pulse (out_pulse),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, out_pulse, out_res.angle, out_res.channel};
  assign m_axis_tlast = out_res.last;

  // checks
  a_update_starts_drain: assert property (@(posedge clk) disable iff (rst)
    update |=> busy && (cnt == '0))
    else $error("update did not start the drain");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (32'(cnt) < CHANNELS))
    else $error("drain counter out of range");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (out_res.channel == 3'(CHANNELS - 1)))
    else $error("last flag on a channel other than the final one");

  a_no_accept_while_draining: assert property (@(posedge clk) disable iff (rst)
    update |=> !s_axis_tready)
    else $error("input accepted during drain");

endmodule
